@@ rtl/kfrc_pkg.sv @@
// shared types, constants and helpers for the k-mer flag read classifier
package kfrc_pkg;

    // counter and field widths
    localparam int COUNT_BITS = 20;
    localparam int OUT_BITS   = 20;
    localparam int K_BITS     = 6;
    localparam int R_BITS     = 16;
    localparam int PROD_BITS  = COUNT_BITS + R_BITS;
    // wide enough for twenty times a counter and for sums against k
    localparam int WIDE_BITS  = COUNT_BITS + 5;
    localparam int TIMES      = 20;

    // queue sizes
    localparam int SQ_DEPTH  = 4;
    localparam int SQ_AW     = $clog2(SQ_DEPTH);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    // register reset values
    localparam logic [K_BITS-1:0] KMER_LEN_RESET = K_BITS'(31);
    localparam logic [R_BITS-1:0] RATIO_RESET    = R_BITS'(21627);

    // register indexes
    localparam logic CFG_KMER_LEN = 1'b0;
    localparam logic CFG_RATIO    = 1'b1;

    // lookup flag codes
    localparam logic [3:0] FLAG_PAT = 4'd2;
    localparam logic [3:0] FLAG_MAT = 4'd8;

    // per-position run types
    localparam logic [1:0] RUN_NONE = 2'd0;
    localparam logic [1:0] RUN_PAT  = 2'd1;
    localparam logic [1:0] RUN_MAT  = 2'd2;

    // read classes
    localparam logic [1:0] CLASS_AMBIG = 2'd0;
    localparam logic [1:0] CLASS_PAT   = 2'd1;
    localparam logic [1:0] CLASS_MAT   = 2'd2;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic       kmer_valid;
        logic [3:0] kmer_flag;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [1:0]          read_class;
        logic [OUT_BITS-1:0] paternal_run_score;
        logic [OUT_BITS-1:0] maternal_run_score;
    } result_t;

    // totals of one finished read
    typedef struct packed {
        count_t pat_count;
        count_t mat_count;
        count_t pat_score;
        count_t mat_score;
    } summary_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // saturating add of two counters
    function automatic count_t sat_add(input count_t a, input count_t b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    // clamp a counter to the output score width
    function automatic logic [OUT_BITS-1:0] clamp_out(input count_t v);
        logic [31:0] w;
        logic [31:0] lim;
        w   = 32'(v);
        lim = (32'd1 << OUT_BITS) - 32'd1;
        return (w > lim) ? '1 : w[OUT_BITS-1:0];
    endfunction

endpackage

@@ rtl/kfrc_front.sv @@
// front end: per-base typing, flag counts, run tracking and read summary
module kfrc_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  kfrc_pkg::item_t           item,
    input  logic [kfrc_pkg::K_BITS-1:0] kmer_len,
    output logic                      sum_push,
    output kfrc_pkg::summary_t        sum_data
);
    import kfrc_pkg::*;

    logic       in_read_reg, in_read_next;
    count_t     pc_reg, pc_next;
    count_t     mc_reg, mc_next;
    logic [1:0] rtype_reg, rtype_next;
    count_t     rlen_reg, rlen_next;
    count_t     ps_reg, ps_next;
    count_t     ms_reg, ms_next;

    logic [1:0]        t;
    logic              same;
    logic              close_old;
    count_t            len_n;
    logic [1:0]        type_n;
    count_t            add_p, add_m;
    count_t            pc_n, mc_n, ps_n, ms_n;
    logic [K_BITS-1:0] thr;
    count_t            thr_w;

    // run length threshold, every run qualifies for short k
    assign thr   = (kmer_len < K_BITS'(4)) ? '0 : kmer_len - K_BITS'(4);
    assign thr_w = COUNT_BITS'(thr);

    // position type from the flag
    always_comb
    begin
        t = RUN_NONE;
        if (item.kmer_valid && item.kmer_flag == FLAG_PAT)
        begin
            t = RUN_PAT;
        end
        else if (item.kmer_valid && item.kmer_flag == FLAG_MAT)
        begin
            t = RUN_MAT;
        end
    end

    // counts and run continuation
    assign pc_n  = (t == RUN_PAT) ? sat_add(pc_reg, COUNT_BITS'(1)) : pc_reg;
    assign mc_n  = (t == RUN_MAT) ? sat_add(mc_reg, COUNT_BITS'(1)) : mc_reg;
    assign same  = in_read_reg && (t == rtype_reg);
    assign len_n = same ? sat_add(rlen_reg, COUNT_BITS'(1)) : COUNT_BITS'(1);
    assign type_n = same ? rtype_reg : t;
    assign close_old = in_read_reg && !same && (rlen_reg >= thr_w);

    // each score takes at most one run per base: the closed old run or,
    // on the last base, the run that ends there
    always_comb
    begin
        add_p = '0;
        add_m = '0;
        if (close_old && rtype_reg == RUN_PAT)
        begin
            add_p = rlen_reg;
        end
        else if (item.last && type_n == RUN_PAT && len_n >= thr_w)
        begin
            add_p = len_n;
        end
        if (close_old && rtype_reg == RUN_MAT)
        begin
            add_m = rlen_reg;
        end
        else if (item.last && type_n == RUN_MAT && len_n >= thr_w)
        begin
            add_m = len_n;
        end
    end

    assign ps_n = sat_add(ps_reg, add_p);
    assign ms_n = sat_add(ms_reg, add_m);

    // summary of a finished read
    assign sum_push = accept && item.last;
    assign sum_data = '{pat_count: pc_n, mat_count: mc_n, pat_score: ps_n, mat_score: ms_n};

    // next state, cleared after the last base
    always_comb
    begin
        in_read_next = in_read_reg;
        pc_next      = pc_reg;
        mc_next      = mc_reg;
        rtype_next   = rtype_reg;
        rlen_next    = rlen_reg;
        ps_next      = ps_reg;
        ms_next      = ms_reg;
        if (accept)
        begin
            if (item.last)
            begin
                in_read_next = 1'b0;
                pc_next      = '0;
                mc_next      = '0;
                rtype_next   = RUN_NONE;
                rlen_next    = '0;
                ps_next      = '0;
                ms_next      = '0;
            end
            else
            begin
                in_read_next = 1'b1;
                pc_next      = pc_n;
                mc_next      = mc_n;
                rtype_next   = type_n;
                rlen_next    = len_n;
                ps_next      = ps_n;
                ms_next      = ms_n;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_read_reg <= 1'b0;
            pc_reg      <= '0;
            mc_reg      <= '0;
            rtype_reg   <= RUN_NONE;
            rlen_reg    <= '0;
            ps_reg      <= '0;
            ms_reg      <= '0;
        end
        else
        begin
            in_read_reg <= in_read_next;
            pc_reg      <= pc_next;
            mc_reg      <= mc_next;
            rtype_reg   <= rtype_next;
            rlen_reg    <= rlen_next;
            ps_reg      <= ps_next;
            ms_reg      <= ms_next;
        end
    end

endmodule

@@ rtl/kfrc_sum_queue.sv @@
// short queue of read summaries between front end and back end
module kfrc_sum_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  kfrc_pkg::summary_t   wr_data,
    input  logic                 rd_en,
    output kfrc_pkg::summary_t   rd_data,
    output kfrc_pkg::q_status_t  status
);
    import kfrc_pkg::*;

    summary_t         mem [SQ_DEPTH];
    logic [SQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [SQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [SQ_AW:0]   cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == (SQ_AW+1)'(SQ_DEPTH));
    assign do_wr   = wr_en && !status.full;
    assign do_rd   = rd_en && !status.empty;
    assign rd_data = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + SQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + SQ_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + (SQ_AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - (SQ_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/kfrc_back.sv @@
// back end: read classification stage and result queue
module kfrc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [kfrc_pkg::K_BITS-1:0] kmer_len,
    input  logic [kfrc_pkg::R_BITS-1:0] ratio_q16,
    input  kfrc_pkg::q_status_t         sq_status,
    input  kfrc_pkg::summary_t          sq_data,
    output logic                        sq_pop,
    output kfrc_pkg::result_t           result,
    output logic                        empty,
    input  logic                        pop
);
    import kfrc_pkg::*;

    typedef logic [WIDE_BITS-1:0] wide_t;

    // compare stage
    logic                 st_valid_reg, st_valid_next;
    logic                 st_zero_reg, st_eq_reg, st_c1_reg, st_c2_reg;
    logic                 st_big_reg, st_d1_reg, st_d2_reg;
    logic [PROD_BITS-1:0] st_pp_reg, st_pm_reg;
    count_t               st_cp_reg, st_cm_reg, st_ps_reg, st_ms_reg;

    // result queue
    result_t           omem [OUT_DEPTH];
    logic [OUT_AW-1:0] owr_ptr_reg, owr_ptr_next;
    logic [OUT_AW-1:0] ord_ptr_reg, ord_ptr_next;
    logic [OUT_AW:0]   out_cnt_reg, out_cnt_next;

    wide_t   cp_w, cm_w, ps_w, ms_w, k_w;
    logic    f_zero, f_eq, f_c1, f_c2, f_big, f_d1, f_d2;
    logic    cmp_p, cmp_m;
    logic [1:0] cls;
    result_t res;
    logic    do_pop;

    // take a summary only when the result queue has room for it
    assign sq_pop = !sq_status.empty &&
                    ((out_cnt_reg + (OUT_AW+1)'(st_valid_reg)) < (OUT_AW+1)'(OUT_DEPTH));
    assign st_valid_next = sq_pop;

    // threshold compares on the summary
    always_comb
    begin
        cp_w   = WIDE_BITS'(sq_data.pat_count);
        cm_w   = WIDE_BITS'(sq_data.mat_count);
        ps_w   = WIDE_BITS'(sq_data.pat_score);
        ms_w   = WIDE_BITS'(sq_data.mat_score);
        k_w    = WIDE_BITS'(kmer_len);
        f_zero = (ps_w == '0) && (ms_w == '0);
        f_eq   = (cp_w == cm_w);
        f_c1   = (cp_w + WIDE_BITS'(4) >= cm_w + k_w) &&
                 ((cm_w <= WIDE_BITS'(1)) || (cp_w > cm_w * WIDE_BITS'(TIMES)));
        f_c2   = (cm_w + WIDE_BITS'(4) >= cp_w + k_w) &&
                 ((cp_w <= WIDE_BITS'(1)) || (cm_w > cp_w * WIDE_BITS'(TIMES)));
        f_big  = (ps_w > k_w) && (ms_w > k_w);
        f_d1   = (ps_w + WIDE_BITS'(4) >= ms_w + k_w) &&
                 (ps_w >= ms_w * WIDE_BITS'(TIMES));
        f_d2   = (ms_w + WIDE_BITS'(4) >= ps_w + k_w) &&
                 (ms_w >= ps_w * WIDE_BITS'(TIMES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    // stage payload with the ratio products
    always_ff @(posedge clk)
    begin
        if (sq_pop)
        begin
            st_zero_reg <= f_zero;
            st_eq_reg   <= f_eq;
            st_c1_reg   <= f_c1;
            st_c2_reg   <= f_c2;
            st_big_reg  <= f_big;
            st_d1_reg   <= f_d1;
            st_d2_reg   <= f_d2;
            st_pp_reg   <= PROD_BITS'(sq_data.pat_count) * PROD_BITS'(ratio_q16);
            st_pm_reg   <= PROD_BITS'(sq_data.mat_count) * PROD_BITS'(ratio_q16);
            st_cp_reg   <= sq_data.pat_count;
            st_cm_reg   <= sq_data.mat_count;
            st_ps_reg   <= sq_data.pat_score;
            st_ms_reg   <= sq_data.mat_score;
        end
    end

    // ratio tests and class decision
    assign cmp_p = st_pp_reg > {st_cm_reg, R_BITS'(0)};
    assign cmp_m = st_pm_reg > {st_cp_reg, R_BITS'(0)};

    always_comb
    begin
        cls = CLASS_AMBIG;
        if (st_zero_reg)
        begin
            if (st_eq_reg)
            begin
                cls = CLASS_AMBIG;
            end
            else if (st_c1_reg)
            begin
                cls = CLASS_PAT;
            end
            else if (st_c2_reg)
            begin
                cls = CLASS_MAT;
            end
        end
        else if (!st_big_reg)
        begin
            if (st_d1_reg && cmp_p)
            begin
                cls = CLASS_PAT;
            end
            else if (st_d2_reg && cmp_m)
            begin
                cls = CLASS_MAT;
            end
        end
    end

    assign res = '{read_class: cls,
                   paternal_run_score: clamp_out(st_ps_reg),
                   maternal_run_score: clamp_out(st_ms_reg)};

    // result queue control
    assign empty  = (out_cnt_reg == '0);
    assign do_pop = pop && !empty;
    assign result = omem[ord_ptr_reg];

    always_comb
    begin
        owr_ptr_next = st_valid_reg ? owr_ptr_reg + OUT_AW'(1) : owr_ptr_reg;
        ord_ptr_next = do_pop ? ord_ptr_reg + OUT_AW'(1) : ord_ptr_reg;
        out_cnt_next = out_cnt_reg;
        if (st_valid_reg && !do_pop)
        begin
            out_cnt_next = out_cnt_reg + (OUT_AW+1)'(1);
        end
        else if (do_pop && !st_valid_reg)
        begin
            out_cnt_next = out_cnt_reg - (OUT_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_valid_reg)
        begin
            omem[owr_ptr_reg] <= res;
        end
    end

    // queued plus in-flight results never exceed the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ((out_cnt_reg + (OUT_AW+1)'(st_valid_reg)) <= (OUT_AW+1)'(OUT_DEPTH)))
        else $error("result queue overrun");

    // a summary taken from the queue reaches the compare stage
    a_pop_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        sq_pop |=> st_valid_reg)
        else $error("summary lost between queue and stage");

    // a staged result lands in the queue when nothing leaves
    a_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid_reg && !(pop && !empty)) |=>
        (out_cnt_reg == $past(out_cnt_reg) + (OUT_AW+1)'(1)))
        else $error("staged result not queued");

endmodule

@@ rtl/kmer_flag_read_classifier_top.sv @@
// top level of the k-mer flag read classifier
//
//   channel   signals                         moves
//   input     push, full, item                one base position per request
//   result    empty, pop, result              one classified read per request
//   config    cfg_we, cfg_index, cfg_data     register write, no wait
//
// one base is accepted every cycle while the summary queue has room; the
// front end updates counts and runs for each accepted base
// a read's result passes from the summary queue through the compare stage
// into the result queue before it shows on the result ports
// reset clears all read state and both queues and loads the register defaults
// full rises only when the summary queue holds four unclassified reads, which
// happens when the result side stalls; the result queue holds four reads
module kmer_flag_read_classifier_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  kfrc_pkg::item_t             item,
    output logic                        empty,
    input  logic                        pop,
    output kfrc_pkg::result_t           result,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [kfrc_pkg::R_BITS-1:0] cfg_data
);
    import kfrc_pkg::*;

    logic [K_BITS-1:0] kmer_len_reg, kmer_len_next;
    logic [R_BITS-1:0] ratio_reg, ratio_next;

    logic       accept;
    logic       sum_push;
    summary_t   sum_data;
    summary_t   sq_data;
    q_status_t  sq_status;
    logic       sq_pop;

    // configuration registers
    always_comb
    begin
        kmer_len_next = kmer_len_reg;
        ratio_next    = ratio_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_KMER_LEN: kmer_len_next = cfg_data[K_BITS-1:0];
                CFG_RATIO:    ratio_next    = cfg_data;
                default:      kmer_len_next = kmer_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_len_reg <= KMER_LEN_RESET;
            ratio_reg    <= RATIO_RESET;
        end
        else
        begin
            kmer_len_reg <= kmer_len_next;
            ratio_reg    <= ratio_next;
        end
    end

    // input handshake
    assign full   = sq_status.full;
    assign accept = push && !full;

    kfrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .kmer_len (kmer_len_reg),
        .sum_push (sum_push),
        .sum_data (sum_data)
    );

    kfrc_sum_queue u_sum_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sum_push),
        .wr_data (sum_data),
        .rd_en   (sq_pop),
        .rd_data (sq_data),
        .status  (sq_status)
    );

    kfrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .kmer_len  (kmer_len_reg),
        .ratio_q16 (ratio_reg),
        .sq_status (sq_status),
        .sq_data   (sq_data),
        .sq_pop    (sq_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
